/* sv/sspq_pkg.sv */
`default_nettype none
package sspq_pkg;

  // queue depth default
  localparam int unsigned DEPTH_DEF = 64;

  // sort key: arrival[39:24] service[23:8] id[7:0]
  localparam int unsigned KEY_W = 40;
  typedef logic [KEY_W-1:0] key_t;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic insert;
    logic finish;
  } ctrl_t;

endpackage
`default_nettype wire

/* sv/single_server_priority_queue.sv */
`default_nettype none
// result: each accepted command beat yields a registered result beat in the following cycle
// throughput: one command per cycle while out_tready stays high; every cell of the
//   sorted chain compares against the new key and shifts in the same cycle
// reset: entry count, busy flag and output valid clear; entry contents are not cleared
module single_server_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,  // customer_id[7:0], arrival_time[23:8], service_time[39:24]
  input  wire  [1:0]  in_tuser,  // cmd[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata  // head_valid[0], head_id[8:1], queue_length[15:9],
                                 // server_busy[16], new_at_head[17], error_code[19:18], zero[23:20]
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          acc;
  logic [1:0]    cmd;
  key_t          key;
  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  logic          empty, full;
  logic [1:0]    err;
  ctrl_t         ctrl;
  logic          out_valid_r;
  logic [23:0]   out_data_r, out_data_nxt;
  logic [7:0]    head_id;

  key_t          cell_data [DEPTH];
  key_t          cell_nxt  [DEPTH];
  logic          cell_take [DEPTH];

  assign acc   = in_tvalid && in_tready;
  assign cmd   = in_tuser;
  // key order: arrival, then service, then id
  assign key   = {in_tdata[23:8], in_tdata[39:24], in_tdata[7:0]};
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));

  // command decode and control state update
  always_comb begin
    count_nxt   = count_r;
    busy_nxt    = busy_r;
    err         = ERR_OK;
    ctrl.insert = 1'b0;
    ctrl.finish = 1'b0;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          ctrl.insert = acc;
          count_nxt   = count_r + CW'(1);
        end
      end
      CMD_START: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          busy_nxt = 1'b1;
        end
      end
      CMD_FINISH: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          ctrl.finish = acc;
          count_nxt   = count_r - CW'(1);
          busy_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // sorted chain of cells, head at index 0
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    key_t left_d, right_d;
    logic left_t;
    if (gi == 0) begin : g_first
      assign left_d = key;
      assign left_t = 1'b0;
    end else begin : g_mid
      assign left_d = cell_data[gi-1];
      assign left_t = cell_take[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign right_d = cell_data[gi];
    end else begin : g_notlast
      assign right_d = cell_data[gi+1];
    end
    sspq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_key    (key),
      .occupied   (count_r > CW'(gi)),
      .pin        ((gi == 0) && busy_r),
      .left_take  (left_t),
      .left_data  (left_d),
      .right_data (right_d),
      .take       (cell_take[gi]),
      .data_r     (cell_data[gi]),
      .data_nxt   (cell_nxt[gi])
    );
  end

  // result beat built from the state after this command
  always_comb begin
    head_id      = (count_nxt != '0) ? cell_nxt[0][7:0] : 8'd0;
    out_data_nxt = {4'd0, err, ctrl.insert && cell_take[0], busy_nxt,
                    7'(count_nxt), head_id, (count_nxt != '0)};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r <= count_nxt;
        busy_r  <= busy_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // busy only with an entry at the head
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (count_r != '0))
    else $error("server busy on empty queue");

  // a new head is reported only on a clean insert
  a_new_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[17]) |-> (out_data_r[0] && (out_data_r[19:18] == ERR_OK)))
    else $error("new_at_head on failed insert");

endmodule
`default_nettype wire

/* sv/sspq_cell.sv */
`default_nettype none
module sspq_cell
  import sspq_pkg::*;
(
  input  wire   clk,
  input  ctrl_t ctrl,
  input  key_t  new_key,
  input  wire   occupied,
  input  wire   pin,
  input  wire   left_take,
  input  key_t  left_data,
  input  key_t  right_data,
  output logic  take,
  output key_t  data_r,
  output key_t  data_nxt
);

  // this cell is at or past the insert point
  assign take = !occupied || ((data_r > new_key) && !pin);

  // insert shifts right from the insert point, finish shifts left
  always_comb begin
    data_nxt = data_r;
    if (ctrl.insert) begin
      if (left_take) begin
        data_nxt = left_data;
      end else if (take) begin
        data_nxt = new_key;
      end
    end else if (ctrl.finish) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire
